>>> design/sha256_pkg.sv
// Package for the SHA-256 hash engine: command/status types, states and constants.
// Used by the controller, the datapath and the top level. No dependencies.
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINISH,
        ST_PAD_WORD,
        ST_FILL,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_OUT
    } state_t;

    // Word source for the schedule window.
    typedef enum logic [2:0] {
        SRC_INPUT,
        SRC_ONE,
        SRC_ZERO,
        SRC_LEN_HI,
        SRC_LEN_LO
    } wsrc_t;

    typedef struct packed {
        logic        place;      // write one word into the block
        wsrc_t       src;
        logic        add_len;    // add accepted bits to the length
        logic        start_blk;  // copy hash into working variables
        logic        round;      // run one round
        logic        finish_blk; // add working variables into hash
        logic        reinit;     // return to initial hash
        logic        shift_out;  // rotate digest output by one word
    } cmd_t;

    typedef struct packed {
        logic [3:0] word_count;
        logic [5:0] round_idx;
    } sts_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage

>>> design/sha256_hash_engine_core.sv
// Top level of the SHA-256 hash engine: controller plus datapath.
// Depends on sha256_pkg, sha256_ctrl and sha256_dp.
//
// Input stream: s_axis_tdata carries one 32-bit big-endian message word and
// s_axis_tuser the count of valid leading bits; s_axis_tlast marks the final
// word of a message. The count is looked at only on the final word.
// Output stream: m_axis_tdata carries the digest words H0 to H7 in order,
// with m_axis_tlast high on H7.
// A word is accepted in the cycle it is offered while the engine is idle. Every
// sixteenth word, counting the padding, closes a 512-bit block that the single
// round unit runs one round per cycle, then adds the result into the hash, with
// the input stalled.
// After the last word the padding and length words go in about one per cycle,
// then the last one or two blocks run and the digest is shown, one word a
// cycle while the receiver takes it; a stalled receiver holds the word.
// Reset loads the initial hash and clears all counters; no input is taken
// until the digest of the current message has been fully delivered.
module sha256_hash_engine_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // message_word
    input  logic [5:0]  s_axis_tuser,   // valid_bits
    input  logic        s_axis_tlast,   // last_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic        m_axis_tlast    // digest_last
);

    sha256_pkg::cmd_t cmd;
    sha256_pkg::sts_t sts;
    logic             in_full;

    sha256_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_full   (in_full),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_end   (m_axis_tlast),
        .cmd       (cmd)
    );

    sha256_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .message_word    (s_axis_tdata),
        .valid_bits      (s_axis_tuser),
        .last_of_message (s_axis_tlast),
        .cmd             (cmd),
        .sts             (sts),
        .in_full         (in_full),
        .digest_word     (m_axis_tdata)
    );

endmodule

>>> design/sha256_ctrl.sv
// Controller state machine for the SHA-256 engine.
// Depends on sha256_pkg for the state, command and status types.
module sha256_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    input  logic              in_full,     // last word carries all 32 bits
    input  logic              out_ready,
    input  sha256_pkg::sts_t  sts,
    output logic              in_ready,
    output logic              out_valid,
    output logic              out_end,
    output sha256_pkg::cmd_t  cmd
);

    sha256_pkg::state_t state_reg, state_next;
    sha256_pkg::state_t ret_reg, ret_next;   // state to resume after a block
    logic [2:0] out_cnt_reg, out_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sha256_pkg::ST_IDLE;
            ret_reg     <= sha256_pkg::ST_IDLE;
            out_cnt_reg <= 3'd0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_comb
    begin
        logic full_blk;
        full_blk     = (sts.word_count == 4'd15);
        state_next   = state_reg;
        ret_next     = ret_reg;
        out_cnt_next = out_cnt_reg;
        cmd          = '0;
        cmd.src      = sha256_pkg::SRC_INPUT;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        out_end      = 1'b0;
        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.place   = 1'b1;
                    cmd.add_len = 1'b1;
                    if (!in_last)
                        ret_next = sha256_pkg::ST_IDLE;
                    else if (in_full)
                        ret_next = sha256_pkg::ST_PAD_WORD;
                    else
                        ret_next = sha256_pkg::ST_FILL;
                    if (full_blk)
                    begin
                        cmd.start_blk = 1'b1;
                        state_next    = sha256_pkg::ST_ROUND;
                    end
                    else
                        state_next = ret_next;
                end
            end
            sha256_pkg::ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (sts.round_idx == 6'd63)
                    state_next = sha256_pkg::ST_FINISH;
            end
            sha256_pkg::ST_FINISH:
            begin
                // The working variables now hold the result of round 63.
                cmd.finish_blk = 1'b1;
                state_next     = ret_reg;
            end
            sha256_pkg::ST_PAD_WORD,
            sha256_pkg::ST_FILL,
            sha256_pkg::ST_LEN_HI,
            sha256_pkg::ST_LEN_LO:
            begin
                cmd.place = 1'b1;
                case (state_reg)
                    sha256_pkg::ST_PAD_WORD:
                    begin
                        cmd.src  = sha256_pkg::SRC_ONE;
                        ret_next = sha256_pkg::ST_FILL;
                    end
                    sha256_pkg::ST_FILL:
                    begin
                        cmd.src = sha256_pkg::SRC_ZERO;
                        // Zeros run up to word 13. At word 15 one zero closes the block;
                        // at word 14 no zero is needed and the length follows directly.
                        if (sts.word_count == 4'd14)
                        begin
                            cmd.place = 1'b0;
                            ret_next  = sha256_pkg::ST_LEN_HI;
                        end
                        else
                            ret_next = (sts.word_count == 4'd13) ? sha256_pkg::ST_LEN_HI
                                                                 : sha256_pkg::ST_FILL;
                    end
                    sha256_pkg::ST_LEN_HI:
                    begin
                        cmd.src  = sha256_pkg::SRC_LEN_HI;
                        ret_next = sha256_pkg::ST_LEN_LO;
                    end
                    default:
                    begin
                        cmd.src  = sha256_pkg::SRC_LEN_LO;
                        ret_next = sha256_pkg::ST_OUT;
                    end
                endcase
                if (full_blk)
                begin
                    cmd.start_blk = 1'b1;
                    state_next    = sha256_pkg::ST_ROUND;
                end
                else
                    state_next = ret_next;
            end
            sha256_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                out_end   = (out_cnt_reg == 3'd7);
                if (out_ready)
                begin
                    cmd.shift_out = 1'b1;
                    out_cnt_next  = out_cnt_reg + 3'd1;
                    if (out_cnt_reg == 3'd7)
                    begin
                        cmd.reinit = 1'b1;
                        state_next = sha256_pkg::ST_IDLE;
                    end
                end
            end
            default:
                state_next = sha256_pkg::ST_IDLE;
        endcase
    end

endmodule

>>> design/sha256_dp.sv
// Datapath of the SHA-256 engine: schedule window, round logic, hash and length.
// Depends on sha256_pkg for commands, status and constants.
module sha256_dp
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       message_word,
    input  logic [5:0]        valid_bits,
    input  logic              last_of_message,
    input  sha256_pkg::cmd_t  cmd,
    output sha256_pkg::sts_t  sts,
    output logic              in_full,
    output logic [31:0]       digest_word
);

    logic [31:0] win_reg [16];
    logic [31:0] hash_reg [8];
    logic [31:0] var_reg [8];
    logic [3:0]  wcnt_reg;
    logic [5:0]  rnd_reg;
    logic [63:0] len_reg;

    logic [5:0]  vb;
    logic [31:0] keep, in_word, place_word, w_cur, s0, s1, w_new;
    logic [31:0] t1, t2, a, e;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    assign vb      = (!last_of_message || valid_bits > 6'd32) ? 6'd32 : valid_bits;
    assign in_full = (vb == 6'd32);
    assign keep    = (vb == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (6'd32 - vb));
    // A short last word carries its padding 1 bit right after the valid bits.
    assign in_word = in_full ? message_word
                             : ((message_word & keep) | (32'h8000_0000 >> vb));

    always_comb
    begin
        case (cmd.src)
            sha256_pkg::SRC_INPUT:  place_word = in_word;
            sha256_pkg::SRC_ONE:    place_word = 32'h8000_0000;
            sha256_pkg::SRC_LEN_HI: place_word = len_reg[63:32];
            sha256_pkg::SRC_LEN_LO: place_word = len_reg[31:0];
            default:                place_word = 32'd0;
        endcase
    end

    // The window is kept as a shift line: entry 0 is the oldest word.
    assign s0    = rotr(win_reg[1], 7) ^ rotr(win_reg[1], 18) ^ (win_reg[1] >> 3);
    assign s1    = rotr(win_reg[14], 17) ^ rotr(win_reg[14], 19) ^ (win_reg[14] >> 10);
    assign w_new = s1 + win_reg[9] + s0 + win_reg[0];
    assign w_cur = win_reg[0];

    assign a  = var_reg[0];
    assign e  = var_reg[4];
    assign t1 = var_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & var_reg[5]) ^ (~e & var_reg[6]))
              + sha256_pkg::ROUND_K[rnd_reg] + w_cur;
    assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & var_reg[1]) ^ (a & var_reg[2]) ^ (var_reg[1] & var_reg[2]));

    always_ff @(posedge clk)
    begin
        if (cmd.place)
            win_reg[wcnt_reg] <= place_word;
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[15] <= w_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= sha256_pkg::INIT_HASH;
            var_reg  <= sha256_pkg::INIT_HASH;
            wcnt_reg <= 4'd0;
            rnd_reg  <= 6'd0;
            len_reg  <= 64'd0;
        end
        else
        begin
            if (cmd.place)
                wcnt_reg <= wcnt_reg + 4'd1;
            if (cmd.add_len)
                len_reg <= len_reg + {58'd0, vb};
            if (cmd.start_blk)
                var_reg <= hash_reg;
            if (cmd.round)
            begin
                rnd_reg <= rnd_reg + 6'd1;
                for (int i = 7; i > 0; i--)
                    var_reg[i] <= var_reg[i - 1];
                var_reg[4] <= var_reg[3] + t1;
                var_reg[0] <= t1 + t2;
            end
            if (cmd.finish_blk)
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= hash_reg[i] + var_reg[i];
            if (cmd.shift_out)
            begin
                for (int i = 0; i < 7; i++)
                    hash_reg[i] <= hash_reg[i + 1];
                hash_reg[7] <= hash_reg[0];
            end
            if (cmd.reinit)
            begin
                hash_reg <= sha256_pkg::INIT_HASH;
                var_reg  <= sha256_pkg::INIT_HASH;
                len_reg  <= 64'd0;
            end
        end
    end

    assign digest_word    = hash_reg[0];
    assign sts.word_count = wcnt_reg;
    assign sts.round_idx  = rnd_reg;

endmodule

>>> design/sha256_checker.sv
// Port-level checker for the SHA-256 engine, bound to the top level.
// Depends only on the top level's ports.
module sha256_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // Input and output are never open in the same cycle.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("input open during digest");

    // A stalled digest word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("digest word dropped under stall");

    // After the final digest word the block is ready for a new message.
    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
        else $error("not idle after digest");

    // A last input request never yields a digest in the very next cycle.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !m_axis_tvalid)
        else $error("digest too early");

endmodule

bind sha256_hash_engine_core sha256_checker u_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

>>> bench/tb_top.sv
// Testbench for sha256_hash_engine_core: random bit messages checked against a SHA-256 predictor.
// Depends on sha256_pkg for the round constants and the initial hash.
`timescale 1ns / 100ps

class digest_scoreboard;
    logic [31:0] chain [8];
    logic [31:0] block [16];
    int          fill;
    logic [63:0] bit_len;
    logic [32:0] pending [$];
    int          errors;

    function new();
        errors = 0;
        restart();
    endfunction

    function void restart();
        for (int i = 0; i < 8; i++)
            chain[i] = sha256_pkg::INIT_HASH[i];
        fill = 0;
        bit_len = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void run_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int t = 0; t < 64; t++)
        begin
            if (t < 16)
                w[t] = block[t];
            else
                w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                     + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        end
        v = chain;
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--)
                v[i] = v[i-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] = chain[i] + v[i];
    endfunction

    function void put_word(logic [31:0] wd);
        block[fill] = wd;
        fill = (fill + 1) % 16;
        if (fill == 0)
            run_block();
    endfunction

    // Notes one accepted request and queues the digest when it ends a message.
    function void note_request(logic [31:0] wd, logic [5:0] vb, logic lst);
        logic [31:0] keep;
        int nb;
        if (!lst)
        begin
            bit_len += 32;
            put_word(wd);
            return;
        end
        nb = (vb > 32) ? 32 : vb;
        bit_len += nb;
        if (nb == 32)
        begin
            put_word(wd);
            put_word(32'h8000_0000);
        end
        else
        begin
            keep = (nb == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - nb));
            put_word((wd & keep) | (32'h8000_0000 >> nb));
        end
        if (fill > 14)
            put_word('0);
        while (fill < 14)
            put_word('0);
        put_word(bit_len[63:32]);
        put_word(bit_len[31:0]);
        for (int i = 0; i < 8; i++)
            pending.insert(pending.size(), {i == 7, chain[i]});
        restart();
    endfunction

    function void check_digest(logic [31:0] wd, logic lst);
        logic [32:0] exp;
        if (pending.size() == 0)
        begin
            $error("unexpected digest word %h", wd);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (wd !== exp[31:0])
        begin
            $error("digest_word expected %h actual %h", exp[31:0], wd);
            errors++;
        end
        if (lst !== exp[32])
        begin
            $error("digest_last expected %b actual %b", exp[32], lst);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [5:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    digest_scoreboard sb;
    bit               hold_long;

    sha256_hash_engine_core dut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Sends one request after a random gap; valid stays high across back-to-back requests.
    task automatic send_word(logic [31:0] wd, logic [5:0] vb, logic lst, bit no_gap);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= wd;
        s_axis_tuser  <= vb;
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(wd, vb, lst);
    endtask

    task automatic send_message(int nwords, int vb, bit no_gap);
        for (int i = 0; i < nwords; i++)
            send_word($urandom(), (i == nwords - 1) ? 6'(vb) : 6'($urandom_range(0, 63)),
                      i == nwords - 1, no_gap);
    endtask

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_digest(m_axis_tdata, m_axis_tlast);

    // Receiver: random stalls per word, plus one long hold-off on request.
    initial
    begin
        int wait_n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_long = 1'b0;
            end
            wait_n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
            if (wait_n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        int n;
        sb = new();
        hold_long = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty, the "abc" vector, every length class and extremes.
        send_word(32'h0, 6'd0, 1'b1, 1'b0);
        send_word(32'h6162_6300, 6'd24, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFF, 6'd32, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFF, 6'd1, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFF, 6'd31, 1'b1, 1'b0);
        send_message(14, 32, 1'b1);
        send_message(14, 0, 1'b0);
        hold_long = 1'b1;
        send_message(16, 32, 1'b1);

        // Random messages, mostly short, some spanning several blocks.
        n = 0;
        while (n < 280)
        begin
            int len;
            int vb;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 6);
            case ($urandom_range(0, 3))
                0: vb = 32;
                1: vb = 0;
                2: vb = $urandom_range(33, 63);
                default: vb = $urandom_range(1, 31);
            endcase
            send_message(len, vb, $urandom_range(0, 3) == 0);
            n += len;
        end
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("sha256_hash_engine_core test passed");
        else
            $display("sha256_hash_engine_core test failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("sha256_hash_engine_core test failed");
        $finish;
    end
endmodule

>>> files.f
design/sha256_pkg.sv
design/sha256_ctrl.sv
design/sha256_dp.sv
design/sha256_hash_engine_core.sv
design/sha256_checker.sv
bench/tb_top.sv
